// ----- design/fasof_pkg.sv -----
// Package for the fix-anchored segment outlier filter.
// Widths, register indexes and solution codes shared by the other files but fasof_ram.
// No dependencies.
package fasof_pkg;
    localparam int RUN_DEPTH  = 32;
    localparam int ADDR_W     = $clog2(RUN_DEPTH);
    localparam int LEN_W      = $clog2(RUN_DEPTH + 1);
    localparam int TIME_W     = 40;
    localparam int POS_W      = 34;
    localparam int DIFF_W     = POS_W + 1;
    localparam int DT_W       = TIME_W + 1;
    localparam int GAP_W      = 32;
    localparam int CNT_W      = 16;
    localparam int MW         = 80;
    localparam int PW         = 2 * MW;
    localparam int ENTRY_W    = 1 + TIME_W + 3 * POS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOAT_ONLY = 3'd5;

    localparam logic [1:0] KIND_FLOAT = 2'd1;
    localparam logic [1:0] KIND_FIXED = 2'd2;

    // ms to s scale, squared side of the speed test
    localparam logic [19:0] SPEED_SCALE = 20'd1000000;

    typedef logic [PW-1:0] t_wide;
endpackage

// ----- design/fasof_in_if.sv -----
// Input epoch channel: valid/ready handshake plus epoch payload.
// Depends on fasof_pkg.
interface fasof_in_if;
    import fasof_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status_kind;
    logic [TIME_W-1:0]       time_ms;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    end_of_stream;

    modport source (output valid, status_kind, time_ms, pos_x, pos_y, pos_z, end_of_stream,
                    input ready);
    modport sink (input valid, status_kind, time_ms, pos_x, pos_y, pos_z, end_of_stream,
                  output ready);
endinterface

// ----- design/fasof_out_if.sv -----
// Decision channel: valid/ready handshake plus per-epoch decision payload.
// Depends on fasof_pkg.
interface fasof_out_if;
    import fasof_pkg::*;
    logic             valid;
    logic             ready;
    logic [15:0]      epoch_index;
    logic             keep;
    logic             overflow_pass;
    logic             last_of_run;
    logic [CNT_W-1:0] inspected_runs;
    logic [CNT_W-1:0] rejected_runs;
    logic [CNT_W-1:0] rej_epoch_count;

    modport source (output valid, epoch_index, keep, overflow_pass, last_of_run,
                    inspected_runs, rejected_runs, rej_epoch_count, input ready);
    modport sink (input valid, epoch_index, keep, overflow_pass, last_of_run,
                  inspected_runs, rejected_runs, rej_epoch_count, output ready);
endinterface

// ----- design/fasof_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fasof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/fasof_mul.sv -----
// Shared shift-add multiplier: one bit of the second operand per cycle.
// Depends on fasof_pkg.
module fasof_mul (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [fasof_pkg::MW-1:0] i_a,
    input  logic [fasof_pkg::MW-1:0] i_b,
    output logic                   o_done,
    output logic [fasof_pkg::PW-1:0] o_p
);
    import fasof_pkg::*;

    logic          r_busy;
    logic [PW-1:0] r_a;
    logic [MW-1:0] r_b;
    logic [PW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_b == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PW'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_busy && (r_b == '0);
    assign o_p    = r_acc;
endmodule

// ----- design/fix_anchored_segment_outlier_filter.sv -----
// Fix-anchored segment outlier filter, top level.
// Depends on fasof_pkg, fasof_in_if, fasof_out_if, fasof_ram, fasof_mul.
//
// Epochs enter on i_in (valid/ready); one decision per epoch leaves on o_out.
// Non-fixed epochs are stored in a 32-entry run buffer with no decision of
// their own; on buffer overflow the run and later non-fixed epochs pass
// with overflow_pass, and end of stream flushes the run too. A fixed epoch
// closes the run: given an anchor and a run of at least the minimum length,
// anchor gap and speed are checked, then every checked epoch gets a residual
// test, and only then are the decisions for the buffered epochs and the
// fixed epoch sent, one beat per cycle while o_out.ready is high,
// last_of_run on the final beat. All products come from one shift-add
// multiplier retiring one bit of its second operand per cycle. i_in.ready
// is low from an accepted epoch that leaves idle until its last decision
// beat is taken; a stalled receiver simply holds the block with the current
// beat on o_out. Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are
// to go in only while idle; the block itself does not enforce this.
// Synchronous active-low reset clears run, anchor valid flag and counters;
// the buffer needs no clearing as only written entries are read. End of
// stream does the same clearing after its last decision.
module fix_anchored_segment_outlier_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fasof_in_if.sink                      i_in,
    fasof_out_if.source                   o_out,
    input  logic                          i_cfg_we,
    input  logic [fasof_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fasof_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fasof_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_GAP    = 5'd1;
    localparam logic [4:0] S_DD     = 5'd2;
    localparam logic [4:0] S_DDW    = 5'd3;
    localparam logic [4:0] S_DM     = 5'd4;
    localparam logic [4:0] S_DMW    = 5'd5;
    localparam logic [4:0] S_SP     = 5'd6;
    localparam logic [4:0] S_SPW    = 5'd7;
    localparam logic [4:0] S_SQ     = 5'd8;
    localparam logic [4:0] S_SQW    = 5'd9;
    localparam logic [4:0] S_LIM    = 5'd10;
    localparam logic [4:0] S_LIMW   = 5'd11;
    localparam logic [4:0] S_LSQ    = 5'd12;
    localparam logic [4:0] S_LSQW   = 5'd13;
    localparam logic [4:0] S_RD     = 5'd14;
    localparam logic [4:0] S_RDW    = 5'd15;
    localparam logic [4:0] S_R1     = 5'd16;
    localparam logic [4:0] S_R1W    = 5'd17;
    localparam logic [4:0] S_R2     = 5'd18;
    localparam logic [4:0] S_R2W    = 5'd19;
    localparam logic [4:0] S_R3     = 5'd20;
    localparam logic [4:0] S_R3W    = 5'd21;
    localparam logic [4:0] S_RCMP   = 5'd22;
    localparam logic [4:0] S_FIXEND = 5'd23;
    localparam logic [4:0] S_EMIT   = 5'd24;

    // configuration
    logic [5:0]  r_min_seg;
    logic [31:0] r_max_gap;
    logic [19:0] r_max_spd;
    logic [19:0] r_min_spd;
    logic [19:0] r_max_res;
    logic        r_float_only;

    // control and run state
    logic [4:0]       r_state;
    logic [LEN_W-1:0] r_run_len;
    logic [15:0]      r_base;
    logic             r_ovfd;
    logic             r_anc_ok;
    logic [15:0]      r_next;
    logic [CNT_W-1:0] r_cnt_insp;
    logic [CNT_W-1:0] r_cnt_rrun;
    logic [CNT_W-1:0] r_cnt_repo;
    logic [1:0]       r_axis;
    logic             r_sel;
    logic [LEN_W-1:0] r_ptr;
    logic             r_any;
    logic [RUN_DEPTH-1:0] r_rej;
    logic [LEN_W-1:0] r_nrun;
    logic [LEN_W-1:0] r_ei;
    logic             r_ovf_run;
    logic             r_ovf_single;
    logic             r_eos;

    // payload
    logic [TIME_W-1:0]       r_time;
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic [15:0]             r_idx;
    logic [TIME_W-1:0]       r_anc_t;
    logic signed [POS_W-1:0] r_anc_x, r_anc_y, r_anc_z;
    logic [GAP_W-1:0]        r_gap;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    t_wide                   r_acc, r_dd, r_lim;
    logic [MW-1:0]           r_tmp;
    logic signed [MW-1:0]    r_m1;
    logic [MW-1:0]           r_rmag;
    logic [TIME_W-1:0]       r_e_t;
    logic signed [POS_W-1:0] r_e_x, r_e_y, r_e_z;

    logic               mul_start, mul_done;
    logic [MW-1:0]      mul_a, mul_b;
    t_wide              mul_p;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;

    logic                     in_acc, out_acc;
    logic [5:0]               min_eff;
    logic [DT_W-1:0]          gap_full, dt;
    logic [DT_W-1:0]          dt_mag;
    logic signed [DIFF_W-1:0] d_ax, ex;
    logic [DIFF_W-1:0]        d_mag, ex_mag;
    logic signed [POS_W-1:0]  e_pos, a_pos;
    logic signed [MW-1:0]     m2, res;
    logic                     single;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign min_eff = (r_min_seg == '0) ? 6'd1 : r_min_seg;

    assign gap_full = {1'b0, r_time} - {1'b0, r_anc_t};
    assign dt       = {1'b0, r_e_t} - {1'b0, r_anc_t};
    assign dt_mag   = dt[DT_W-1] ? -dt : dt;

    always_comb begin
        case (r_axis)
            2'd0: begin
                d_ax  = r_dx;
                e_pos = r_e_x;
                a_pos = r_anc_x;
            end
            2'd1: begin
                d_ax  = r_dy;
                e_pos = r_e_y;
                a_pos = r_anc_y;
            end
            default: begin
                d_ax  = r_dz;
                e_pos = r_e_z;
                a_pos = r_anc_z;
            end
        endcase
    end

    assign ex     = DIFF_W'(e_pos) - DIFF_W'(a_pos);
    assign d_mag  = d_ax[DIFF_W-1] ? DIFF_W'(-d_ax) : DIFF_W'(d_ax);
    assign ex_mag = ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
    assign m2     = (d_ax[DIFF_W-1] ^ dt[DT_W-1]) ? -$signed(mul_p[MW-1:0])
                                                  : $signed(mul_p[MW-1:0]);
    assign res    = r_m1 - m2;

    // multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            S_DD: begin
                mul_start = 1'b1;
                mul_a     = MW'(d_mag);
                mul_b     = MW'(d_mag);
            end
            S_DM: begin
                mul_start = 1'b1;
                mul_a     = r_acc[MW-1:0];
                mul_b     = MW'(SPEED_SCALE);
            end
            S_SP: begin
                mul_start = 1'b1;
                mul_a     = r_sel ? MW'(r_min_spd) : MW'(r_max_spd);
                mul_b     = MW'(r_gap);
            end
            S_SQ, S_LSQ: begin
                mul_start = 1'b1;
                mul_a     = r_tmp;
                mul_b     = r_tmp;
            end
            S_LIM: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_max_res);
                mul_b     = MW'(r_gap);
            end
            S_R1: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_gap);
                mul_b     = MW'(ex_mag);
            end
            S_R2: begin
                mul_start = 1'b1;
                mul_a     = MW'(d_mag);
                mul_b     = MW'(dt_mag);
            end
            S_R3: begin
                mul_start = 1'b1;
                mul_a     = r_rmag;
                mul_b     = r_rmag;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    fasof_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign ram_we = (r_state == S_IDLE) && in_acc && (i_in.status_kind != KIND_FIXED) &&
                    !r_ovfd && (32'(r_run_len) < RUN_DEPTH) && !i_in.end_of_stream;

    fasof_ram #(.WIDTH(ENTRY_W), .DEPTH(RUN_DEPTH)) u_run_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_run_len[ADDR_W-1:0]),
        .i_wdata ({i_in.status_kind == KIND_FLOAT, i_in.time_ms,
                   i_in.pos_x, i_in.pos_y, i_in.pos_z}),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_seg    <= 6'd1;
            r_max_gap    <= 32'd30000;
            r_max_spd    <= 20'd1024;
            r_min_spd    <= 20'd0;
            r_max_res    <= 20'd512;
            r_float_only <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_SEG:    r_min_seg    <= i_cfg_data[5:0];
                REG_MAX_GAP:    r_max_gap    <= i_cfg_data;
                REG_MAX_SPEED:  r_max_spd    <= i_cfg_data[19:0];
                REG_MIN_SPEED:  r_min_spd    <= i_cfg_data[19:0];
                REG_MAX_RES:    r_max_res    <= i_cfg_data[19:0];
                REG_FLOAT_ONLY: r_float_only <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_time <= i_in.time_ms;
                    r_px   <= i_in.pos_x;
                    r_py   <= i_in.pos_y;
                    r_pz   <= i_in.pos_z;
                    r_idx  <= r_next;
                end
            end
            S_GAP: begin
                r_gap <= gap_full[GAP_W-1:0];
                r_dx  <= DIFF_W'(r_px) - DIFF_W'(r_anc_x);
                r_dy  <= DIFF_W'(r_py) - DIFF_W'(r_anc_y);
                r_dz  <= DIFF_W'(r_pz) - DIFF_W'(r_anc_z);
                r_acc <= '0;
            end
            S_DDW, S_R3W: begin
                if (mul_done) r_acc <= r_acc + mul_p;
            end
            S_DMW: begin
                if (mul_done) r_dd <= mul_p;
            end
            S_SPW, S_LIMW: begin
                if (mul_done) r_tmp <= mul_p[MW-1:0];
            end
            S_LSQW: begin
                if (mul_done) r_lim <= mul_p;
            end
            S_RDW: begin
                r_e_t <= ram_rdata[ENTRY_W-2 -: TIME_W];
                r_e_x <= ram_rdata[3*POS_W-1 -: POS_W];
                r_e_y <= ram_rdata[2*POS_W-1 -: POS_W];
                r_e_z <= ram_rdata[POS_W-1:0];
                r_acc <= '0;
            end
            S_R1W: begin
                if (mul_done) begin
                    r_m1 <= ex[DIFF_W-1] ? -$signed(mul_p[MW-1:0]) : $signed(mul_p[MW-1:0]);
                end
            end
            S_R2W: begin
                if (mul_done) r_rmag <= res[MW-1] ? MW'(-res) : MW'(res);
            end
            S_FIXEND: begin
                r_anc_t <= r_time;
                r_anc_x <= r_px;
                r_anc_y <= r_py;
                r_anc_z <= r_pz;
            end
            S_EMIT: begin
                if (out_acc && r_ei == r_nrun && r_eos) begin
                    r_anc_t <= '0;
                    r_anc_x <= '0;
                    r_anc_y <= '0;
                    r_anc_z <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_len    <= '0;
            r_base       <= '0;
            r_ovfd       <= 1'b0;
            r_anc_ok     <= 1'b0;
            r_next       <= '0;
            r_cnt_insp   <= '0;
            r_cnt_rrun   <= '0;
            r_cnt_repo   <= '0;
            r_axis       <= '0;
            r_sel        <= 1'b0;
            r_ptr        <= '0;
            r_any        <= 1'b0;
            r_rej        <= '0;
            r_nrun       <= '0;
            r_ei         <= '0;
            r_ovf_run    <= 1'b0;
            r_ovf_single <= 1'b0;
            r_eos        <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_next       <= r_next + 16'd1;
                        r_rej        <= '0;
                        r_any        <= 1'b0;
                        r_ei         <= '0;
                        r_eos        <= i_in.end_of_stream;
                        r_ovf_run    <= 1'b0;
                        r_ovf_single <= 1'b0;
                        r_nrun       <= r_run_len;
                        if (i_in.status_kind == KIND_FIXED) begin
                            if (!r_anc_ok || 32'(r_run_len) < 32'(min_eff)) begin
                                r_state <= S_FIXEND;
                            end else begin
                                r_state <= S_GAP;
                            end
                        end else if (r_ovfd) begin
                            r_nrun       <= '0;
                            r_ovf_single <= 1'b1;
                            r_state      <= S_EMIT;
                        end else if (32'(r_run_len) >= RUN_DEPTH) begin
                            r_ovf_run    <= 1'b1;
                            r_ovf_single <= 1'b1;
                            r_ovfd       <= 1'b1;
                            r_run_len    <= '0;
                            r_state      <= S_EMIT;
                        end else if (i_in.end_of_stream) begin
                            r_run_len <= '0;
                            r_state   <= S_EMIT;
                        end else begin
                            if (r_run_len == '0) r_base <= r_next;
                            r_run_len <= r_run_len + LEN_W'(1);
                        end
                    end
                end
                S_GAP: begin
                    if (gap_full[DT_W-1] || gap_full == '0 ||
                        gap_full[TIME_W-1:0] > TIME_W'(r_max_gap)) begin
                        r_state <= S_FIXEND;
                    end else begin
                        r_axis  <= '0;
                        r_state <= S_DD;
                    end
                end
                S_DD:   r_state <= S_DDW;
                S_DDW: begin
                    if (mul_done) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_DM;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_DD;
                        end
                    end
                end
                S_DM:   r_state <= S_DMW;
                S_DMW: begin
                    if (mul_done) begin
                        r_sel   <= 1'b0;
                        r_state <= S_SP;
                    end
                end
                S_SP:   r_state <= S_SPW;
                S_SPW:  if (mul_done) r_state <= S_SQ;
                S_SQ:   r_state <= S_SQW;
                S_SQW: begin
                    if (mul_done) begin
                        if ((!r_sel && r_dd > mul_p) || (r_sel && r_dd < mul_p)) begin
                            r_state <= S_FIXEND;
                        end else if (!r_sel) begin
                            r_sel   <= 1'b1;
                            r_state <= S_SP;
                        end else begin
                            r_state <= S_LIM;
                        end
                    end
                end
                S_LIM:  r_state <= S_LIMW;
                S_LIMW: if (mul_done) r_state <= S_LSQ;
                S_LSQ:  r_state <= S_LSQW;
                S_LSQW: begin
                    if (mul_done) begin
                        if (r_cnt_insp != '1) r_cnt_insp <= r_cnt_insp + CNT_W'(1);
                        r_ptr   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_ptr == r_run_len) begin
                        if (r_any && r_cnt_rrun != '1) r_cnt_rrun <= r_cnt_rrun + CNT_W'(1);
                        r_state <= S_FIXEND;
                    end else begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    // float flag sits at the top of the entry
                    if (r_float_only && !ram_rdata[ENTRY_W-1]) begin
                        r_ptr   <= r_ptr + LEN_W'(1);
                        r_state <= S_RD;
                    end else begin
                        r_axis  <= '0;
                        r_state <= S_R1;
                    end
                end
                S_R1:   r_state <= S_R1W;
                S_R1W:  if (mul_done) r_state <= S_R2;
                S_R2:   r_state <= S_R2W;
                S_R2W:  if (mul_done) r_state <= S_R3;
                S_R3:   r_state <= S_R3W;
                S_R3W: begin
                    if (mul_done) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_RCMP;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_R1;
                        end
                    end
                end
                S_RCMP: begin
                    if (r_acc > r_lim) begin
                        r_rej[r_ptr[ADDR_W-1:0]] <= 1'b1;
                        r_any <= 1'b1;
                        if (r_cnt_repo != '1) r_cnt_repo <= r_cnt_repo + CNT_W'(1);
                    end
                    r_ptr   <= r_ptr + LEN_W'(1);
                    r_state <= S_RD;
                end
                S_FIXEND: begin
                    r_anc_ok  <= 1'b1;
                    r_ovfd    <= 1'b0;
                    r_run_len <= '0;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_acc) begin
                        if (r_ei == r_nrun) begin
                            r_state <= S_IDLE;
                            if (r_eos) begin
                                r_run_len  <= '0;
                                r_base     <= '0;
                                r_ovfd     <= 1'b0;
                                r_anc_ok   <= 1'b0;
                                r_next     <= '0;
                                r_cnt_insp <= '0;
                                r_cnt_rrun <= '0;
                                r_cnt_repo <= '0;
                            end
                        end else begin
                            r_ei <= r_ei + LEN_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the epoch itself follows the buffered run as the final beat
    assign single = (r_ei == r_nrun);

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = (r_state == S_EMIT);
    assign o_out.epoch_index     = single ? r_idx : r_base + 16'(r_ei);
    assign o_out.keep            = single ? 1'b1 : !r_rej[r_ei[ADDR_W-1:0]];
    assign o_out.overflow_pass   = single ? r_ovf_single : r_ovf_run;
    assign o_out.last_of_run     = single;
    assign o_out.inspected_runs  = r_cnt_insp;
    assign o_out.rejected_runs   = r_cnt_rrun;
    assign o_out.rej_epoch_count = r_cnt_repo;
endmodule
